// ===== rtl/sldf_pkg.sv =====
package sldf_pkg;

  localparam int unsigned DataW        = 8;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CfgW         = 7;
  localparam int unsigned WordW        = 16;
  localparam int unsigned PayloadDepth = 58;
  localparam int unsigned AddrW        = $clog2(PayloadDepth);

  localparam logic [CfgW-1:0]  MaxFrameBytes = 7'd64;
  localparam logic [CfgW-1:0]  Overhead      = 7'd6;
  localparam logic [WordW-1:0] MarkStart     = 16'd16018;
  localparam logic [WordW-1:0] MarkEnd       = 16'd16108;

  // result kinds carried on tuser
  localparam logic [StatW-1:0] StatByte  = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatFail  = 2'd2;

  typedef enum logic [3:0] {
    StStart0,
    StStart1,
    StLen0,
    StLen1,
    StPayload,
    StEnd0,
    StEnd1,
    StFailed,
    StEmitRd,
    StEmitWr
  } state_e;

  typedef enum logic [1:0] {
    LoadNone,
    LoadByte,
    LoadEmpty,
    LoadFail
  } load_e;

  // controller -> datapath
  typedef struct packed {
    logic  hold_low;   // capture low byte of a 16-bit field
    logic  take_len;   // latch payload length from the length word
    logic  wr_payload; // store byte at count, advance count
    logic  clr_cnt;    // zero the byte count
    logic  rd_issue;   // read store at count into read register
    logic  adv_cnt;    // advance count during emission
    load_e load;       // fill the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_ok;
    logic end_ok;
    logic len_bad;
    logic len_empty;
    logic payload_done;
    logic emit_last;
    logic plen_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/signature_length_frame_decoder.sv =====
// Channel   Direction  Handshake                       Contents
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata[7:0] rx_byte
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata[7:0] payload_byte,
//                                                      tuser[1:0] status, tlast last
// cfg       in         cfg_valid_i / cfg_ready_o       cfg_data_i[6:0] max_frame_len
//
// Input bytes are taken one per cycle while the output register is empty or
// being drained in the same cycle; a frame with payload that passes its end
// check then holds off input while each payload byte is read from the store
// and then loaded into the output register, with sink stalls adding to it.
// Reset (rst_ni low, asynchronous) returns the controller to the start
// marker search, empties the output register and sets max_frame_len to 64.
// After a framing failure every later byte is taken and dropped until reset.
module signature_length_frame_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: received bytes
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  // master side: results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] payload_byte
  output logic [1:0]                    m_axis_tuser,  // [1:0] status
  output logic                          m_axis_tlast,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sldf_pkg::CfgW-1:0]     cfg_data_i     // [6:0] max_frame_len
);

  sldf_pkg::cmd_t cmd;
  sldf_pkg::sts_t sts;

  // the register is always free to take a write
  assign cfg_ready_o = 1'b1;

  // sequencing of marker, length, payload and emission phases
  sldf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // marker compare, length check, payload store and output register
  sldf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ===== rtl/sldf_ctrl.sv =====
module sldf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sldf_pkg::sts_t sts_i,
  output sldf_pkg::cmd_t cmd_o
);

  sldf_pkg::state_e state_q, state_d;
  logic             in_fire;

  always_comb begin
    in_ready_o = sts_i.out_free && (state_q != sldf_pkg::StEmitRd) &&
                 (state_q != sldf_pkg::StEmitWr);
  end

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sldf_pkg::StStart0;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sldf_pkg::StStart0: if (in_fire) state_d = sldf_pkg::StStart1;
      sldf_pkg::StStart1: begin
        if (in_fire) state_d = sts_i.start_ok ? sldf_pkg::StLen0 : sldf_pkg::StFailed;
      end
      sldf_pkg::StLen0: if (in_fire) state_d = sldf_pkg::StLen1;
      sldf_pkg::StLen1: begin
        if (in_fire) begin
          priority if (sts_i.len_bad) state_d = sldf_pkg::StFailed;
          else if (sts_i.len_empty)   state_d = sldf_pkg::StEnd0;
          else                        state_d = sldf_pkg::StPayload;
        end
      end
      sldf_pkg::StPayload: if (in_fire && sts_i.payload_done) state_d = sldf_pkg::StEnd0;
      sldf_pkg::StEnd0: if (in_fire) state_d = sldf_pkg::StEnd1;
      sldf_pkg::StEnd1: begin
        if (in_fire) begin
          priority if (!sts_i.end_ok) state_d = sldf_pkg::StFailed;
          else if (sts_i.plen_zero)   state_d = sldf_pkg::StStart0;
          else                        state_d = sldf_pkg::StEmitRd;
        end
      end
      sldf_pkg::StFailed: state_d = sldf_pkg::StFailed;
      sldf_pkg::StEmitRd: state_d = sldf_pkg::StEmitWr;
      sldf_pkg::StEmitWr: begin
        if (sts_i.out_free) state_d = sts_i.emit_last ? sldf_pkg::StStart0 : sldf_pkg::StEmitRd;
      end
      default: state_d = sldf_pkg::StFailed;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '{hold_low: 1'b0, take_len: 1'b0, wr_payload: 1'b0, clr_cnt: 1'b0,
              rd_issue: 1'b0, adv_cnt: 1'b0, load: sldf_pkg::LoadNone};
    unique case (state_q)
      sldf_pkg::StStart0, sldf_pkg::StLen0, sldf_pkg::StEnd0: begin
        cmd_o.hold_low = in_fire;
      end
      sldf_pkg::StStart1: begin
        if (in_fire && !sts_i.start_ok) cmd_o.load = sldf_pkg::LoadFail;
      end
      sldf_pkg::StLen1: begin
        if (in_fire) begin
          if (sts_i.len_bad) begin
            cmd_o.load = sldf_pkg::LoadFail;
          end else begin
            cmd_o.take_len = 1'b1;
            cmd_o.clr_cnt  = 1'b1;
          end
        end
      end
      sldf_pkg::StPayload: cmd_o.wr_payload = in_fire;
      sldf_pkg::StEnd1: begin
        if (in_fire) begin
          priority if (!sts_i.end_ok) cmd_o.load = sldf_pkg::LoadFail;
          else if (sts_i.plen_zero)   cmd_o.load = sldf_pkg::LoadEmpty;
          else                        cmd_o.clr_cnt = 1'b1;
        end
      end
      sldf_pkg::StFailed: ;
      sldf_pkg::StEmitRd: cmd_o.rd_issue = 1'b1;
      sldf_pkg::StEmitWr: begin
        if (sts_i.out_free) begin
          cmd_o.load    = sldf_pkg::LoadByte;
          cmd_o.adv_cnt = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sldf_dp.sv =====
module sldf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sldf_pkg::DataW-1:0]    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [sldf_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [sldf_pkg::StatW-1:0]    out_status_o,
  output logic [sldf_pkg::DataW-1:0]    out_byte_o,
  output logic                          out_last_o,
  input  sldf_pkg::cmd_t                cmd_i,
  output sldf_pkg::sts_t                sts_o
);

  logic [sldf_pkg::CfgW-1:0]  max_len_q;
  logic [sldf_pkg::DataW-1:0] held_q;
  logic [sldf_pkg::AddrW-1:0] plen_q;
  logic [sldf_pkg::AddrW-1:0] cnt_q;
  logic [sldf_pkg::DataW-1:0] rdata_q;
  logic [sldf_pkg::DataW-1:0] mem_q [sldf_pkg::PayloadDepth];

  logic                       out_valid_q;
  logic [sldf_pkg::StatW-1:0] out_status_q;
  logic [sldf_pkg::DataW-1:0] out_byte_q;
  logic                       out_last_q;

  logic [sldf_pkg::WordW-1:0] word;
  logic [sldf_pkg::CfgW-1:0]  limit;
  logic [sldf_pkg::CfgW-1:0]  cnt_inc;
  logic                       emit_last;

  assign word      = {rx_byte_i, held_q};
  assign limit     = (max_len_q > sldf_pkg::MaxFrameBytes) ? sldf_pkg::MaxFrameBytes
                                                          : max_len_q;
  assign cnt_inc   = {1'b0, cnt_q} + 7'd1;
  assign emit_last = (cnt_inc == {1'b0, plen_q});

  always_comb begin
    sts_o.start_ok     = (word == sldf_pkg::MarkStart);
    sts_o.end_ok       = (word == sldf_pkg::MarkEnd);
    sts_o.len_bad      = (word < {9'd0, sldf_pkg::Overhead}) || (word > {9'd0, limit});
    sts_o.len_empty    = (word == {9'd0, sldf_pkg::Overhead});
    sts_o.payload_done = (cnt_inc >= {1'b0, plen_q});
    sts_o.emit_last    = emit_last;
    sts_o.plen_zero    = (plen_q == '0);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sldf_pkg::MaxFrameBytes;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      plen_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.hold_low) held_q <= rx_byte_i;
      // length already checked to lie in [6, 64]
      if (cmd_i.take_len) plen_q <= sldf_pkg::AddrW'(word[sldf_pkg::CfgW-1:0] -
                                                     sldf_pkg::Overhead);
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.wr_payload || cmd_i.adv_cnt) begin
        cnt_q <= cnt_inc[sldf_pkg::AddrW-1:0];
      end
    end
  end

  // payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_payload) mem_q[cnt_q] <= rx_byte_i;
    if (cmd_i.rd_issue)   rdata_q <= mem_q[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load != sldf_pkg::LoadNone) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.load)
      sldf_pkg::LoadByte: begin
        out_status_q <= sldf_pkg::StatByte;
        out_byte_q   <= rdata_q;
        out_last_q   <= emit_last;
      end
      sldf_pkg::LoadEmpty: begin
        out_status_q <= sldf_pkg::StatEmpty;
        out_byte_q   <= '0;
        out_last_q   <= 1'b1;
      end
      sldf_pkg::LoadFail: begin
        out_status_q <= sldf_pkg::StatFail;
        out_byte_q   <= '0;
        out_last_q   <= 1'b1;
      end
      sldf_pkg::LoadNone: ;
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== rtl/sldf_chk.sv =====
module sldf_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // empty and failure results stand alone, with zero data
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == sldf_pkg::StatEmpty ||
                      m_axis_tuser == sldf_pkg::StatFail)
    |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("empty or failure result not a lone marked item");

  // nothing follows a delivered failure
  a_fail_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == sldf_pkg::StatFail)
    |=> !m_axis_tvalid)
    else $error("result after failure");

  // input is only taken when the output register can take a new result
  a_in_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken with a blocked output register");

endmodule

bind signature_length_frame_decoder sldf_chk u_sldf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sldf_pkg::*;

  // One result as it leaves the m_axis side: tuser, tdata, tlast.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [DataW-1:0] data;
    logic             last;
  } result_t;

  // One directed row: the byte to send and, where it is obvious, the result it closes.
  typedef struct packed {
    logic [DataW-1:0] rx;
    logic             typed;
    result_t          want;
  } stim_row_t;

  // Ways to break the stream at the very end; only one fits a run since
  // a failure locks the block until reset.
  typedef enum int {
    BreakStart,
    BreakShort,
    BreakLong,
    BreakEnd,
    BreakLimit
  } break_e;

  localparam logic [DataW-1:0] StartLo = MarkStart[7:0];
  localparam logic [DataW-1:0] StartHi = MarkStart[15:8];
  localparam logic [DataW-1:0] EndLo   = MarkEnd[7:0];
  localparam logic [DataW-1:0] EndHi   = MarkEnd[15:8];
  localparam result_t          NoRes   = '0;

  // Clock edges to hold after the last result before touching the register,
  // as spare margin once the block has drained every owed result.
  localparam int SettleCycles = 4;

  localparam int DirRowCount = 20;
  localparam stim_row_t DirRows [DirRowCount] = '{
    // empty payload: the smallest legal frame
    '{StartLo, 1'b0, NoRes}, '{StartHi, 1'b0, NoRes},
    '{8'h06,   1'b0, NoRes}, '{8'h00,   1'b0, NoRes},
    '{EndLo,   1'b0, NoRes}, '{EndHi,   1'b1, '{StatEmpty, 8'h00, 1'b1}},
    // one payload byte, all ones
    '{StartLo, 1'b0, NoRes}, '{StartHi, 1'b0, NoRes},
    '{8'h07,   1'b0, NoRes}, '{8'h00,   1'b0, NoRes},
    '{8'hFF,   1'b0, NoRes},
    '{EndLo,   1'b0, NoRes}, '{EndHi,   1'b1, '{StatByte, 8'hFF, 1'b1}},
    // one payload byte, all zeros
    '{StartLo, 1'b0, NoRes}, '{StartHi, 1'b0, NoRes},
    '{8'h07,   1'b0, NoRes}, '{8'h00,   1'b0, NoRes},
    '{8'h00,   1'b0, NoRes},
    '{EndLo,   1'b0, NoRes}, '{EndHi,   1'b1, '{StatByte, 8'h00, 1'b1}}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [7:0] rx_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;         // [7:0] payload_byte
  logic [1:0]       m_axis_tuser;         // [1:0] status
  logic             m_axis_tlast;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i    = '0;   // [6:0] max_frame_len

  signature_length_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Deframer shadow state, updated once per accepted item.
  state_e           phase_q;
  int               count_q;
  logic [WordW-1:0] frame_len_q;
  logic [DataW-1:0] low_byte_q;
  logic [DataW-1:0] payload_q [MaxFrameBytes];
  logic [CfgW-1:0]  max_len_q;

  result_t decoded_q [$];  // results still owed by the block, oldest first
  result_t fresh_q   [$];  // results caused by the item just decoded
  int      bad_count   = 0;
  int      items_sent  = 0;
  bit      calm        = 1'b0;  // no idling on either side
  bit      steady      = 1'b0;  // no idling for the current frame

  function automatic int eff_limit(input logic [CfgW-1:0] v);
    return (v > MaxFrameBytes) ? int'(MaxFrameBytes) : int'(v);
  endfunction

  // Advance the shadow deframer by one byte and collect what it emits.
  task automatic deframe_byte(input logic [DataW-1:0] b);
    logic [WordW-1:0] word;
    int               plen;
    word = {b, low_byte_q};
    fresh_q.delete();
    case (phase_q)
      StStart0: begin
        low_byte_q = b;
        phase_q    = StStart1;
      end
      StLen0: begin
        low_byte_q = b;
        phase_q    = StLen1;
      end
      StEnd0: begin
        low_byte_q = b;
        phase_q    = StEnd1;
      end
      StStart1: begin
        if (word != MarkStart) begin
          phase_q = StFailed;
          fresh_q.push_back('{StatFail, 8'h00, 1'b1});
        end else begin
          phase_q = StLen0;
        end
      end
      StLen1: begin
        frame_len_q = word;
        // check both bounds against the register value in force right now
        if (word < WordW'(Overhead) || int'(word) > eff_limit(max_len_q)) begin
          phase_q = StFailed;
          fresh_q.push_back('{StatFail, 8'h00, 1'b1});
        end else begin
          count_q = 0;
          phase_q = (word == WordW'(Overhead)) ? StEnd0 : StPayload;
        end
      end
      StPayload: begin
        payload_q[count_q] = b;
        count_q++;
        if (count_q >= int'(frame_len_q) - int'(Overhead)) phase_q = StEnd0;
      end
      StEnd1: begin
        if (word != MarkEnd) begin
          phase_q = StFailed;
          fresh_q.push_back('{StatFail, 8'h00, 1'b1});
        end else begin
          plen = int'(frame_len_q) - int'(Overhead);
          if (plen == 0) begin
            fresh_q.push_back('{StatEmpty, 8'h00, 1'b1});
          end else begin
            for (int i = 0; i < plen; i++) begin
              fresh_q.push_back('{StatByte, payload_q[i], logic'(i == plen - 1)});
            end
          end
          phase_q = StStart0;
          count_q = 0;
        end
      end
      default: begin
        // locked after a failure: swallow everything
        phase_q = StFailed;
      end
    endcase
  endtask

  // Offer one item, maybe after an idle burst; decode it once the block takes it.
  task automatic push_byte(input logic [DataW-1:0] b, input logic typed = 1'b0,
                           input result_t want = '0);
    int gap;
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    deframe_byte(b);
    // a typed row overrides the predictor for that item
    if (typed) begin
      decoded_q.push_back(want);
    end else begin
      foreach (fresh_q[i]) decoded_q.push_back(fresh_q[i]);
    end
  endtask

  // Hold input until every owed result has come, then let the block settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [CfgW-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(input logic [WordW-1:0] start_word, input logic [WordW-1:0] len,
                            input int payload_n, input logic [WordW-1:0] end_word);
    steady = ($urandom_range(0, 3) == 0);
    push_byte(start_word[7:0]);
    push_byte(start_word[15:8]);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    repeat (payload_n) push_byte(8'($urandom_range(0, 255)));
    push_byte(end_word[7:0]);
    push_byte(end_word[15:8]);
  endtask

  // Well-formed frame; mostly short payloads, now and then the largest allowed.
  task automatic send_good_frame(input bit go_max);
    int room;
    int p;
    room = eff_limit(max_len_q) - int'(Overhead);
    if (go_max || $urandom_range(0, 11) == 0) p = room;
    else p = $urandom_range(0, (room < 12) ? room : 12);
    send_frame(MarkStart, WordW'(p + int'(Overhead)), p, MarkEnd);
  endtask

  // Random sink stalls in bursts; none while calm or steady.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && !calm && !steady && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every accepted result against the oldest one owed.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: status %0d data %02h last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        bad_count++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          bad_count++;
        end
        if (m_axis_tdata !== want.data) begin
          $error("payload_byte: expected %02h, got %02h", want.data, m_axis_tdata);
          bad_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          bad_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    break_e           how;
    logic [WordW-1:0] word;
    int               p;
    phase_q     = StStart0;
    count_q     = 0;
    frame_len_q = '0;
    low_byte_q  = '0;
    max_len_q   = MaxFrameBytes;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset limit
    for (int r = 0; r < DirRowCount; r++) begin
      push_byte(DirRows[r].rx, DirRows[r].typed, DirRows[r].want);
    end

    // smallest legal limit: only empty frames get through
    write_max_len(Overhead);
    repeat (3) send_good_frame(1'b0);

    // limit above the frame maximum of 64 clamps to it; start with a full frame
    write_max_len(7'd127);
    send_good_frame(1'b1);
    while (items_sent < 120) send_good_frame(1'b0);

    write_max_len(7'($urandom_range(7, 63)));
    while (items_sent < 190) send_good_frame(1'b0);

    write_max_len(MaxFrameBytes);
    send_good_frame(1'b1);
    while (items_sent < 210) send_good_frame(1'b0);

    // last stretch at full rate on both sides
    calm = 1'b1;
    while (items_sent < 262) send_good_frame(1'b0);

    // break the stream once, then feed bytes that must all be swallowed
    how = break_e'($urandom_range(0, 4));
    case (how)
      BreakStart: begin
        word = 16'($urandom_range(0, 65535));
        if (word == MarkStart) word[0] = ~word[0];
        send_frame(word, 16'h0006, 0, MarkEnd);
      end
      BreakShort: begin
        send_frame(MarkStart, 16'($urandom_range(0, 5)), 0, MarkEnd);
      end
      BreakLong: begin
        word = 16'($urandom_range(eff_limit(max_len_q) + 1, 65535));
        send_frame(MarkStart, word, 2, MarkEnd);
      end
      BreakEnd: begin
        word = 16'($urandom_range(0, 65535));
        if (word == MarkEnd) word[15] = ~word[15];
        p = $urandom_range(0, 8);
        send_frame(MarkStart, 16'(p + int'(Overhead)), p, word);
      end
      default: begin
        // a limit below the overhead rejects every length
        write_max_len(7'($urandom_range(0, 5)));
        p = $urandom_range(0, 4);
        send_frame(MarkStart, 16'(p + int'(Overhead)), p, MarkEnd);
      end
    endcase
    repeat ($urandom_range(8, 16)) push_byte(8'($urandom_range(0, 255)));

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
